>>> rtl/sdtq_pkg.sv
// shared types, codes and defaults for the sorted deadline timer queue
// no dependencies; used by sdtq_cell and sorted_deadline_timer_queue_core
package sdtq_pkg;

   // defaults for the top level parameters
   localparam int NUM_TIMERS_DEF = 16;
   localparam int COUNT_BITS_DEF = 32;

   // fixed field widths of the request and response beats
   localparam int TIMER_ID_W = 4;
   localparam int DURATION_W = 32;
   localparam int QUERY_W    = 32;
   localparam int KIND_W     = 3;
   localparam int ID_SLOTS   = 2 ** TIMER_ID_W;

   // request operation codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CREATE  = 2'd1,
      OP_COMPARE = 2'd2
   } sdtq_op_type;

   // response kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ARMED     = 3'd0,
      KIND_REJECTED  = 3'd1,
      KIND_EXPIRED   = 3'd2,
      KIND_TICK_NONE = 3'd3,
      KIND_COMPARE   = 3'd4
   } sdtq_kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REBASE,
      ST_INSERT,
      ST_REPLY,
      ST_EXPIRE
   } sdtq_state_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_POP,
      CMD_REBASE
   } sdtq_cmd_type;

   // what a cell holds besides its deadline
   typedef struct packed {
      logic                  valid;
      logic [TIMER_ID_W-1:0] id;
      logic                  handler;
   } sdtq_tag_type;

   // control group from the controller to the cells
   typedef struct packed {
      sdtq_cmd_type cmd;
      sdtq_tag_type new_tag;
   } sdtq_ctl_type;

endpackage

>>> rtl/sdtq_cell.sv
// one cell of the deadline-sorted chain: holds one armed timer
// depends on sdtq_pkg for the tag and control types
module sdtq_cell #(
   parameter int COUNT_BITS = sdtq_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sdtq_pkg::sdtq_ctl_type ctl,
   input  logic [COUNT_BITS-1:0] new_dl,
   input  logic [COUNT_BITS-1:0] count,
   input  logic                  left_ge,
   input  sdtq_pkg::sdtq_tag_type left_tag,
   input  logic [COUNT_BITS-1:0] left_dl,
   input  sdtq_pkg::sdtq_tag_type right_tag,
   input  logic [COUNT_BITS-1:0] right_dl,
   output logic                  ge,
   output sdtq_pkg::sdtq_tag_type tag,
   output logic [COUNT_BITS-1:0] dl
);
   import sdtq_pkg::*;

   sdtq_tag_type          tag_ff, tag_in;
   logic [COUNT_BITS-1:0] dl_ff, dl_in;

   // empty cells sit at the tail and count as later than anything
   assign ge  = !tag_ff.valid || (dl_ff >= new_dl);
   assign tag = tag_ff;
   assign dl  = dl_ff;

   // next contents of this cell
   always_comb begin
      tag_in = tag_ff;
      dl_in  = dl_ff;
      case (ctl.cmd)
         CMD_HOLD: begin
         end
         CMD_INSERT: begin
            if (ge) begin
               if (left_ge) begin
                  tag_in = left_tag;
                  dl_in  = left_dl;
               end else begin
                  tag_in = ctl.new_tag;
                  dl_in  = new_dl;
               end
            end
         end
         CMD_POP: begin
            tag_in = right_tag;
            dl_in  = right_dl;
         end
         CMD_REBASE: begin
            if (tag_ff.valid) begin
               dl_in = dl_ff - count;
            end
         end
         default: begin
         end
      endcase
   end

   // valid flag is control state, deadline is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
      dl_ff <= dl_in;
   end

endmodule

>>> rtl/sorted_deadline_timer_queue_core.sv
// Tick timer queue: requests are taken one at a time (at most one open). A compare or a
// rejected create passes from the request beat through the REPLY state into the response
// register; a create that arms a slot passes INSERT first, and REBASE before that when the
// counter is rebased. A tick enters EXPIRE, where the head cell of the chain retires one
// timer a cycle unless the response stalls. Synchronous reset empties the chain, clears the
// tick count and all busy flags at once; no clearing pass is needed.
// Depends on sdtq_pkg and sdtq_cell.
module sorted_deadline_timer_queue_core #(
   parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF,
   parameter int COUNT_BITS = sdtq_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic [sdtq_pkg::TIMER_ID_W-1:0] req_timer_id,
   input  logic [sdtq_pkg::DURATION_W-1:0] req_duration,
   input  logic                            req_has_handler,
   input  logic [sdtq_pkg::QUERY_W-1:0]    req_query_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sdtq_pkg::KIND_W-1:0]     rsp_kind,
   output logic [sdtq_pkg::TIMER_ID_W-1:0] rsp_expired_id,
   output logic                            rsp_handler_flag,
   output logic                            rsp_reached,
   output logic                            rsp_last
);
   import sdtq_pkg::*;

   localparam int CMP_W   = (COUNT_BITS > QUERY_W) ? COUNT_BITS : QUERY_W;
   localparam int RANGE_W = (TIMER_ID_W > 16) ? TIMER_ID_W + 1 : 17;

   // controller state
   sdtq_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [ID_SLOTS-1:0]   busy_ff, busy_in;
   logic [COUNT_BITS-1:0] new_dl_ff, new_dl_in;
   logic [TIMER_ID_W-1:0] id_ff, id_in;
   logic                  handler_ff, handler_in;
   sdtq_kind_type         pend_kind_ff, pend_kind_in;
   logic                  pend_reached_ff, pend_reached_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   sdtq_kind_type         rsp_kind_ff, rsp_kind_in;
   logic [TIMER_ID_W-1:0] rsp_expired_id_ff, rsp_expired_id_in;
   logic                  rsp_handler_flag_ff, rsp_handler_flag_in;
   logic                  rsp_reached_ff, rsp_reached_in;
   logic                  rsp_last_ff, rsp_last_in;

   // cell chain wiring
   sdtq_ctl_type          ctl;
   sdtq_tag_type          tag_w [NUM_TIMERS];
   logic [COUNT_BITS-1:0] dl_w  [NUM_TIMERS];
   logic                  ge_w  [NUM_TIMERS];

   // request decode helpers
   logic [COUNT_BITS-1:0] dur_trim;
   logic [COUNT_BITS-1:0] sum;
   logic                  wrap;
   logic                  in_range;
   logic                  out_free;
   logic                  head_exp;
   logic                  next_exp;

   assign dur_trim = COUNT_BITS'(req_duration);
   assign sum      = count_ff + dur_trim;
   assign wrap     = sum < dur_trim;
   assign in_range = RANGE_W'(req_timer_id) < RANGE_W'(NUM_TIMERS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign head_exp = tag_w[0].valid && (dl_w[0] <= count_ff);
   assign next_exp = tag_w[1].valid && (dl_w[1] <= count_ff);

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_expired_id   = rsp_expired_id_ff;
   assign rsp_handler_flag = rsp_handler_flag_ff;
   assign rsp_reached      = rsp_reached_ff;
   assign rsp_last         = rsp_last_ff;

   // chain of cells, head at index 0
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      sdtq_tag_type          l_tag;
      logic [COUNT_BITS-1:0] l_dl;
      logic                  l_ge;
      sdtq_tag_type          r_tag;
      logic [COUNT_BITS-1:0] r_dl;

      if (i == 0) begin : g_head
         assign l_tag = '0;
         assign l_dl  = '0;
         assign l_ge  = 1'b0;
      end else begin : g_mid
         assign l_tag = tag_w[i-1];
         assign l_dl  = dl_w[i-1];
         assign l_ge  = ge_w[i-1];
      end

      if (i == NUM_TIMERS - 1) begin : g_tail
         assign r_tag = '0;
         assign r_dl  = '0;
      end else begin : g_body
         assign r_tag = tag_w[i+1];
         assign r_dl  = dl_w[i+1];
      end

      sdtq_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_dl    (new_dl_ff),
         .count     (count_ff),
         .left_ge   (l_ge),
         .left_tag  (l_tag),
         .left_dl   (l_dl),
         .right_tag (r_tag),
         .right_dl  (r_dl),
         .ge        (ge_w[i]),
         .tag       (tag_w[i]),
         .dl        (dl_w[i])
      );
   end

   // next state, chain command and response load
   always_comb begin
      state_in            = state_ff;
      count_in            = count_ff;
      busy_in             = busy_ff;
      new_dl_in           = new_dl_ff;
      id_in               = id_ff;
      handler_in          = handler_ff;
      pend_kind_in        = pend_kind_ff;
      pend_reached_in     = pend_reached_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_kind_in         = rsp_kind_ff;
      rsp_expired_id_in   = rsp_expired_id_ff;
      rsp_handler_flag_in = rsp_handler_flag_ff;
      rsp_reached_in      = rsp_reached_ff;
      rsp_last_in         = rsp_last_ff;
      ctl.cmd             = CMD_HOLD;
      ctl.new_tag.valid   = 1'b1;
      ctl.new_tag.id      = id_ff;
      ctl.new_tag.handler = handler_ff;

      // response beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in      = req_timer_id;
               handler_in = req_has_handler;
               case (req_operation)
                  OP_TICK: begin
                     count_in = count_ff + 1'b1;
                     state_in = ST_EXPIRE;
                  end
                  OP_CREATE: begin
                     if (!in_range || busy_ff[req_timer_id]) begin
                        pend_kind_in    = KIND_REJECTED;
                        pend_reached_in = 1'b0;
                        state_in        = ST_REPLY;
                     end else if (wrap) begin
                        new_dl_in = dur_trim;
                        state_in  = ST_REBASE;
                     end else begin
                        new_dl_in = sum;
                        state_in  = ST_INSERT;
                     end
                  end
                  OP_COMPARE: begin
                     pend_kind_in    = KIND_COMPARE;
                     pend_reached_in = CMP_W'(count_ff) >= CMP_W'(req_query_time);
                     state_in        = ST_REPLY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REBASE: begin
            // shift every deadline down by the count, then restart the count
            ctl.cmd  = CMD_REBASE;
            count_in = '0;
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            ctl.cmd         = CMD_INSERT;
            busy_in[id_ff]  = 1'b1;
            pend_kind_in    = KIND_ARMED;
            pend_reached_in = 1'b0;
            state_in        = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pend_kind_ff;
               rsp_expired_id_in   = '0;
               rsp_handler_flag_in = 1'b0;
               rsp_reached_in      = pend_reached_ff;
               rsp_last_in         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         ST_EXPIRE: begin
            // retire the head while it has expired, one beat per slot
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_reached_in     = 1'b0;
               if (head_exp) begin
                  ctl.cmd                = CMD_POP;
                  busy_in[tag_w[0].id]   = 1'b0;
                  rsp_kind_in            = KIND_EXPIRED;
                  rsp_expired_id_in      = tag_w[0].id;
                  rsp_handler_flag_in    = tag_w[0].handler;
                  rsp_last_in            = !next_exp;
                  if (!next_exp) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rsp_kind_in         = KIND_TICK_NONE;
                  rsp_expired_id_in   = '0;
                  rsp_handler_flag_in = 1'b0;
                  rsp_last_in         = 1'b1;
                  state_in            = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_dl_ff           <= new_dl_in;
      id_ff               <= id_in;
      handler_ff          <= handler_in;
      pend_kind_ff        <= pend_kind_in;
      pend_reached_ff     <= pend_reached_in;
      rsp_kind_ff         <= rsp_kind_in;
      rsp_expired_id_ff   <= rsp_expired_id_in;
      rsp_handler_flag_ff <= rsp_handler_flag_in;
      rsp_reached_ff      <= rsp_reached_in;
      rsp_last_ff         <= rsp_last_in;
   end

endmodule

>>> verif/sorted_deadline_timer_queue_core_tb.sv
// self-checking testbench for sorted_deadline_timer_queue_core: directed and random traffic
// on the request and response channels, predicted by a shadow timer list inside the bench
// depends on sdtq_pkg and the sorted_deadline_timer_queue_core rtl
module sorted_deadline_timer_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdtq_pkg::*;

   localparam int          NUM_SLOTS          = NUM_TIMERS_DEF;
   localparam logic [1:0]  OP_UNUSED          = 2'd3;
   localparam logic [31:0] WIDE_DURATION_BASE = 32'hFFFFF000;
   localparam int          IDLE_LIMIT         = 4000;
   localparam int          DRAIN_CYCLES       = 40;
   localparam int          MAX_REPORTS        = 10;

   // one response beat as the shadow list predicts it
   typedef struct packed {
      sdtq_kind_type         kind;
      logic [TIMER_ID_W-1:0] slot;
      logic                  handler;
      logic                  reached;
      logic                  last;
   } timer_reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_operation;
   logic [TIMER_ID_W-1:0] req_timer_id;
   logic [DURATION_W-1:0] req_duration;
   logic                  req_has_handler;
   logic [QUERY_W-1:0]    req_query_time;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KIND_W-1:0]     rsp_kind;
   logic [TIMER_ID_W-1:0] rsp_expired_id;
   logic                  rsp_handler_flag;
   logic                  rsp_reached;
   logic                  rsp_last;

   // shadow copy of the timer state
   logic [31:0]           shadow_count;
   logic [31:0]           shadow_deadline [NUM_SLOTS];
   logic                  shadow_busy [NUM_SLOTS];
   logic                  shadow_handler [NUM_SLOTS];
   logic [TIMER_ID_W-1:0] due_order [$];

   timer_reply_type awaited_replies [$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  items_sent     = 0;
   int  armed_total    = 0;
   int  rejected_total = 0;
   int  expired_total  = 0;
   int  compare_total  = 0;
   int  rebase_total   = 0;
   int  wide_left      = 3;
   bit  gapless_run    = 1'b0;

   sorted_deadline_timer_queue_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_timer_id     (req_timer_id),
      .req_duration     (req_duration),
      .req_has_handler  (req_has_handler),
      .req_query_time   (req_query_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_expired_id   (rsp_expired_id),
      .rsp_handler_flag (rsp_handler_flag),
      .rsp_reached      (rsp_reached),
      .rsp_last         (rsp_last)
   );

   // clock generation
   always #5 clock = ~clock;

   // shadow timer list: updates state and queues the replies one request causes
   task automatic predict_timer_request(input logic [1:0] op, input logic [TIMER_ID_W-1:0] id,
                                        input logic [31:0] dur, input logic hh,
                                        input logic [31:0] q);
      logic [31:0]           sum;
      logic [TIMER_ID_W-1:0] slot;
      int                    pos;
      int                    fired;
      bit                    more;
      timer_reply_type       r;
      case (op)
         OP_TICK: begin
            shadow_count = shadow_count + 32'd1;
            fired = 0;
            more = due_order.size() > 0 && shadow_deadline[due_order[0]] <= shadow_count;
            // retire due slots from the head, last flag on the final one
            while (more) begin
               slot = due_order.pop_front();
               shadow_busy[slot] = 1'b0;
               fired++;
               more = due_order.size() > 0 && fired < NUM_SLOTS &&
                      shadow_deadline[due_order[0]] <= shadow_count;
               r = '{kind: KIND_EXPIRED, slot: slot, handler: shadow_handler[slot],
                     reached: 1'b0, last: !more};
               awaited_replies.push_back(r);
               expired_total++;
            end
            if (fired == 0) begin
               r = '{kind: KIND_TICK_NONE, slot: '0, handler: 1'b0, reached: 1'b0, last: 1'b1};
               awaited_replies.push_back(r);
            end
         end
         OP_CREATE: begin
            if (shadow_busy[id]) begin
               r = '{kind: KIND_REJECTED, slot: '0, handler: 1'b0, reached: 1'b0, last: 1'b1};
               rejected_total++;
            end else begin
               sum = shadow_count + dur;
               // deadline wrapped: shift every armed deadline down and restart the count
               if (sum < dur) begin
                  for (int i = 0; i < NUM_SLOTS; i++)
                     if (shadow_busy[i]) shadow_deadline[i] = shadow_deadline[i] - shadow_count;
                  shadow_count = '0;
                  sum = dur;
                  rebase_total++;
               end
               shadow_busy[id] = 1'b1;
               shadow_deadline[id] = sum;
               shadow_handler[id] = hh;
               // new slot goes ahead of equal or later deadlines
               pos = 0;
               while (pos < due_order.size() && shadow_deadline[due_order[pos]] < sum) pos++;
               due_order.insert(pos, id);
               r = '{kind: KIND_ARMED, slot: '0, handler: 1'b0, reached: 1'b0, last: 1'b1};
               armed_total++;
            end
            awaited_replies.push_back(r);
         end
         OP_COMPARE: begin
            r = '{kind: KIND_COMPARE, slot: '0, handler: 1'b0,
                  reached: shadow_count >= q, last: 1'b1};
            awaited_replies.push_back(r);
            compare_total++;
         end
         default: ;
      endcase
   endtask

   // random request gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (gapless_run) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one request beat, wait for it to be taken, then predict its replies
   task automatic send_request(input logic [1:0] op, input logic [TIMER_ID_W-1:0] id,
                               input logic [31:0] dur, input logic hh, input logic [31:0] q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation   <= op;
      req_timer_id    <= id;
      req_duration    <= dur;
      req_has_handler <= hh;
      req_query_time  <= q;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_timer_request(op, id, dur, hh, q);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // compare one accepted response beat with the oldest awaited reply
   task automatic check_timer_reply();
      timer_reply_type exp_r;
      if (awaited_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected response kind=%0d id=%0d hf=%0d reached=%0d last=%0d",
                     $realtime, rsp_kind, rsp_expired_id, rsp_handler_flag, rsp_reached,
                     rsp_last);
      end else begin
         exp_r = awaited_replies.pop_front();
         if (rsp_kind !== exp_r.kind || rsp_expired_id !== exp_r.slot ||
             rsp_handler_flag !== exp_r.handler || rsp_reached !== exp_r.reached ||
             rsp_last !== exp_r.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: mismatch expected kind=%0d id=%0d hf=%0d reached=%0d last=%0d, %s",
                        $realtime, exp_r.kind, exp_r.slot, exp_r.handler, exp_r.reached,
                        exp_r.last,
                        $sformatf("got kind=%0d id=%0d hf=%0d reached=%0d last=%0d",
                                  rsp_kind, rsp_expired_id, rsp_handler_flag, rsp_reached,
                                  rsp_last));
         end
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_timer_reply();
   end

   // cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // watchdog
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: %0d cycles without a beat, %0d replies outstanding",
               idle_cycles, awaited_replies.size());
      $display("Regression FAIL");
      $finish;
   end

   // response back-pressure: single-cycle stalls, long stalls and quiet stretches
   initial begin
      int r;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else if (r < 65) begin
            rsp_stall <= 1'b0;
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(8, 40)) @(negedge clock);
         end
      end
   end

   // compare answers at the query time extremes, plus an unused opcode
   task automatic test_compare_edges();
      send_request(OP_COMPARE, '0, '0, 1'b0, 32'd0);
      send_request(OP_COMPARE, 4'hF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
      send_request(OP_UNUSED, TIMER_ID_W'($urandom), $urandom, 1'b1, $urandom);
      send_request(OP_COMPARE, '0, '0, 1'b0, 32'd1);
   endtask

   // many slots on equal deadlines, a busy reject, then multi-slot expiry
   task automatic test_burst_expiry();
      for (int i = 0; i < 12; i++)
         send_request(OP_CREATE, i[TIMER_ID_W-1:0], i % 3, i[0], '0);
      send_request(OP_CREATE, 4'd5, 32'd9, 1'b1, '0);
      repeat (3) send_request(OP_TICK, TIMER_ID_W'($urandom), $urandom, 1'($urandom),
                              $urandom);
   endtask

   // wrapping deadline forces a rebase with a short timer still armed
   task automatic test_counter_rebase();
      send_request(OP_CREATE, 4'd3, 32'd4, 1'b1, '0);
      send_request(OP_TICK, '0, '0, 1'b0, '0);
      send_request(OP_CREATE, 4'd15, 32'hFFFFFFFF, 1'b0, '0);
      send_request(OP_COMPARE, '0, '0, 1'b0, 32'd0);
      send_request(OP_COMPARE, '0, '0, 1'b0, 32'd1);
      repeat (3) send_request(OP_TICK, TIMER_ID_W'($urandom), $urandom, 1'($urandom),
                              $urandom);
   endtask

   // random mix of ticks, creates and compares with mostly short durations
   task automatic test_random_traffic(input int item_goal);
      int          r;
      int          start;
      logic [1:0]  op;
      logic [31:0] dur;
      logic [31:0] q;
      start = items_sent;
      while (items_sent - start < item_goal) begin
         if ($urandom_range(0, 59) == 0) gapless_run = !gapless_run;
         r = $urandom_range(0, 99);
         dur = $urandom;
         q = $urandom;
         if (r < 45) begin
            op = OP_TICK;
         end else if (r < 80) begin
            op = OP_CREATE;
            r = $urandom_range(0, 99);
            if (r < 70) dur = $urandom_range(0, 12);
            else if (r < 95) dur = $urandom_range(0, 300);
            else if (wide_left > 0) begin
               wide_left--;
               dur = WIDE_DURATION_BASE | $urandom_range(0, 'hFFF);
            end else dur = $urandom_range(0, 12);
         end else if (r < 95) begin
            op = OP_COMPARE;
            if ($urandom_range(0, 2) != 0) q = shadow_count + $urandom_range(0, 6) - 3;
         end else begin
            op = OP_UNUSED;
         end
         send_request(op, TIMER_ID_W'($urandom), dur, 1'($urandom), q);
      end
      gapless_run = 1'b0;
   endtask

   // main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_TICK;
      req_timer_id    = '0;
      req_duration    = '0;
      req_has_handler = 1'b0;
      req_query_time  = '0;
      shadow_count    = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_deadline[i] = '0;
         shadow_busy[i]     = 1'b0;
         shadow_handler[i]  = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_compare_edges();
      test_burst_expiry();
      test_counter_rebase();
      test_random_traffic(400);

      req_valid <= 1'b0;
      wait (awaited_replies.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d armed, %0d busy rejects, %0d expiries, %0d compares",
               items_sent, armed_total, rejected_total, expired_total, compare_total);
      $display("counter rebases: %0d, mismatching or unexpected beats: %0d",
               rebase_total, mismatch_count);
      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
